// ===== src/rapm_pkg.sv =====
// Shared types and constants for the RGBA16 alpha premultiply converter.
package rapm_pkg;

  // Channel width and the largest channel value.
  localparam int unsigned CHAN_W = 16;
  localparam logic [CHAN_W-1:0] CHAN_MAX = '1;

  // Number of colour channels handled side by side.
  localparam int unsigned NUM_COLOURS = 3;

  // Mode register codes; the unused code behaves as pass-through.
  localparam logic [1:0] MODE_PASS    = 2'd0;
  localparam logic [1:0] MODE_UNPREMUL = 2'd1;
  localparam logic [1:0] MODE_PREMUL  = 2'd2;

  // One input pixel as it arrives.
  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
    logic              last;
  } pix_t;

  // Per-channel divider state. While run is set, rem holds the partial
  // remainder and val shifts dividend bits out at the top and quotient bits
  // in at the bottom. While run is clear, val already holds the result.
  typedef struct packed {
    logic              run;
    logic [CHAN_W-1:0] rem;
    logic [CHAN_W-1:0] val;
  } chan_t;

  // One pixel in flight through the cell row.
  typedef struct packed {
    chan_t [NUM_COLOURS-1:0] ch;
    logic  [CHAN_W-1:0]      alpha;
    logic                    last;
    logic                    sat;
  } item_t;

endpackage

// ===== src/rapm_if.sv =====
// Stream and configuration interfaces of the RGBA16 alpha premultiply converter.
interface rapm_pix_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] red_in;
  logic [15:0] green_in;
  logic [15:0] blue_in;
  logic [15:0] alpha_in;
  logic        last_in;

  modport source (output valid, red_in, green_in, blue_in, alpha_in, last_in,
                  input ready);
  modport sink (input valid, red_in, green_in, blue_in, alpha_in, last_in,
                output ready);
endinterface

interface rapm_pix_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] red_out;
  logic [15:0] green_out;
  logic [15:0] blue_out;
  logic [15:0] alpha_out;
  logic        overflow;
  logic        last_out;

  modport source (output valid, red_out, green_out, blue_out, alpha_out, overflow,
                  last_out, input ready);
  modport sink (input valid, red_out, green_out, blue_out, alpha_out, overflow,
                last_out, output ready);
endinterface

interface rapm_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== src/rgba16_alpha_premultiply_convert.sv =====
// Top level of the RGBA16 alpha premultiply converter.
//
// Converts one RGBA pixel with 16-bit channels per transfer. Mode 0 passes
// the pixel through, mode 1 unpremultiplies (colour*65535/alpha, zero for
// zero alpha, saturating at 65535 with the overflow flag when colour exceeds
// alpha) and mode 2 premultiplies ((colour*alpha)>>16); alpha and last pass
// unchanged. A new pixel is accepted every clock unless output backpressure
// stalls the row. Each pixel passes through one setup stage and then a row
// of 16 divider cells that each resolve one quotient bit for all three
// colours; the last cell's register drives the output. Each stage stalls
// only when it is full and the stage after it does not move, so bubbles
// close up under output backpressure. The mode register accepts a write
// every cycle and should be changed only while no pixel is in flight.
module rgba16_alpha_premultiply_convert (
  input logic          clk,
  input logic          rst,
  rapm_cfg_if.sink     cfg,
  rapm_pix_in_if.sink  pix_in,
  rapm_pix_out_if.source pix_out
);

  localparam int unsigned NUM_CELLS = rapm_pkg::CHAN_W;

  logic [1:0]      mode;
  rapm_pkg::pix_t  in_pix;
  logic            stage_valid [NUM_CELLS+1];
  logic            stage_ready [NUM_CELLS+1];
  rapm_pkg::item_t stage_item  [NUM_CELLS+1];
  rapm_pkg::item_t out_item;

  // Mode register.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= rapm_pkg::MODE_PASS;
    end else if (cfg.valid) begin
      mode <= cfg.data;
    end
  end

  // Setup stage.
  assign in_pix = '{red:   pix_in.red_in,
                    green: pix_in.green_in,
                    blue:  pix_in.blue_in,
                    alpha: pix_in.alpha_in,
                    last:  pix_in.last_in};

  rapm_prep u_prep (
    .clk        (clk),
    .rst        (rst),
    .mode       (mode),
    .up_valid   (pix_in.valid),
    .up_ready   (pix_in.ready),
    .up_pix     (in_pix),
    .down_valid (stage_valid[0]),
    .down_ready (stage_ready[0]),
    .down_item  (stage_item[0])
  );

  // Row of divider cells.
  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    rapm_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .up_valid   (stage_valid[k]),
      .up_ready   (stage_ready[k]),
      .up_item    (stage_item[k]),
      .down_valid (stage_valid[k+1]),
      .down_ready (stage_ready[k+1]),
      .down_item  (stage_item[k+1])
    );
  end

  // Output side.
  assign out_item            = stage_item[NUM_CELLS];
  assign stage_ready[NUM_CELLS] = pix_out.ready;
  assign pix_out.valid       = stage_valid[NUM_CELLS];
  assign pix_out.red_out     = out_item.ch[0].val;
  assign pix_out.green_out   = out_item.ch[1].val;
  assign pix_out.blue_out    = out_item.ch[2].val;
  assign pix_out.alpha_out   = out_item.alpha;
  assign pix_out.overflow    = out_item.sat;
  assign pix_out.last_out    = out_item.last;

  // An overflowing pixel carries at least one saturated colour.
  a_overflow_sat: assert property (@(posedge clk) disable iff (rst)
    pix_out.valid && pix_out.overflow |->
      (pix_out.red_out == rapm_pkg::CHAN_MAX) ||
      (pix_out.green_out == rapm_pkg::CHAN_MAX) ||
      (pix_out.blue_out == rapm_pkg::CHAN_MAX))
    else $error("overflow flagged without a saturated colour");

  // Zero alpha never saturates.
  a_overflow_alpha: assert property (@(posedge clk) disable iff (rst)
    pix_out.valid && pix_out.overflow |-> pix_out.alpha_out != '0)
    else $error("overflow flagged with zero alpha");

  // With the output stage empty, the whole row can take a transfer.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !pix_out.valid |-> pix_in.ready)
    else $error("input stalled while output stage is empty");

  // The row is empty in the first cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst && $past(rst) |-> !pix_out.valid)
    else $error("output valid right after reset");

endmodule

// ===== src/rapm_prep.sv =====
// Entry stage: sets up premultiply, pass-through or the divider operands.
module rapm_prep (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [1:0]           mode,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  rapm_pkg::pix_t       up_pix,
  output logic                 down_valid,
  input  logic                 down_ready,
  output rapm_pkg::item_t      down_item
);

  logic [rapm_pkg::CHAN_W-1:0]   colour [rapm_pkg::NUM_COLOURS];
  logic [2*rapm_pkg::CHAN_W-1:0] scaled [rapm_pkg::NUM_COLOURS];
  logic [2*rapm_pkg::CHAN_W-1:0] prod   [rapm_pkg::NUM_COLOURS];
  rapm_pkg::item_t               item_next;

  assign colour[0] = up_pix.red;
  assign colour[1] = up_pix.green;
  assign colour[2] = up_pix.blue;

  // The stage takes a transfer when it is empty or its content moves on.
  assign up_ready = !down_valid || down_ready;

  // Per-channel setup: colour*65535 as a shift and subtract, colour*alpha
  // for premultiply, and the saturation test for unpremultiply.
  always_comb begin
    item_next       = '0;
    item_next.alpha = up_pix.alpha;
    item_next.last  = up_pix.last;
    for (int i = 0; i < rapm_pkg::NUM_COLOURS; i++) begin
      scaled[i] = {colour[i], {rapm_pkg::CHAN_W{1'b0}}}
                  - {{rapm_pkg::CHAN_W{1'b0}}, colour[i]};
      prod[i]   = {{rapm_pkg::CHAN_W{1'b0}}, colour[i]}
                  * {{rapm_pkg::CHAN_W{1'b0}}, up_pix.alpha};
      unique case (mode)
        rapm_pkg::MODE_UNPREMUL: begin
          if (up_pix.alpha == '0) begin
            item_next.ch[i].val = '0;
          end else if (colour[i] > up_pix.alpha) begin
            // The quotient would exceed the channel range.
            item_next.ch[i].val = rapm_pkg::CHAN_MAX;
            item_next.sat       = 1'b1;
          end else begin
            item_next.ch[i].run = 1'b1;
            item_next.ch[i].rem = scaled[i][2*rapm_pkg::CHAN_W-1:rapm_pkg::CHAN_W];
            item_next.ch[i].val = scaled[i][rapm_pkg::CHAN_W-1:0];
          end
        end
        rapm_pkg::MODE_PREMUL: begin
          item_next.ch[i].val = prod[i][2*rapm_pkg::CHAN_W-1:rapm_pkg::CHAN_W];
        end
        default: begin
          item_next.ch[i].val = colour[i];
        end
      endcase
    end
  end

  // Stage register.
  always_ff @(posedge clk) begin
    if (rst) begin
      down_valid <= 1'b0;
    end else if (up_ready) begin
      down_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      down_item <= item_next;
    end
  end

endmodule

// ===== src/rapm_cell.sv =====
// One divider cell: resolves one quotient bit for each colour channel.
module rapm_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            up_valid,
  output logic            up_ready,
  input  rapm_pkg::item_t up_item,
  output logic            down_valid,
  input  logic            down_ready,
  output rapm_pkg::item_t down_item
);

  logic [rapm_pkg::CHAN_W:0] trial [rapm_pkg::NUM_COLOURS];
  logic [rapm_pkg::CHAN_W:0] diff  [rapm_pkg::NUM_COLOURS];
  logic                      ge    [rapm_pkg::NUM_COLOURS];
  rapm_pkg::item_t           item_next;

  assign up_ready = !down_valid || down_ready;

  // Restoring division step: bring down the next dividend bit and
  // subtract alpha where it fits. Channels that are done pass unchanged.
  always_comb begin
    item_next = up_item;
    for (int i = 0; i < rapm_pkg::NUM_COLOURS; i++) begin
      trial[i] = {up_item.ch[i].rem, up_item.ch[i].val[rapm_pkg::CHAN_W-1]};
      diff[i]  = trial[i] - {1'b0, up_item.alpha};
      ge[i]    = trial[i] >= {1'b0, up_item.alpha};
      if (up_item.ch[i].run) begin
        item_next.ch[i].rem = ge[i] ? diff[i][rapm_pkg::CHAN_W-1:0]
                                    : trial[i][rapm_pkg::CHAN_W-1:0];
        item_next.ch[i].val = {up_item.ch[i].val[rapm_pkg::CHAN_W-2:0], ge[i]};
      end
    end
  end

  // Cell register.
  always_ff @(posedge clk) begin
    if (rst) begin
      down_valid <= 1'b0;
    end else if (up_ready) begin
      down_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      down_item <= item_next;
    end
  end

endmodule

// ===== sim/rgba16_alpha_premultiply_convert_tb.sv =====
// Self-checking testbench for the RGBA16 alpha premultiply converter, with randomized pixel streams.
module rgba16_alpha_premultiply_convert_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // The fourth mode code is unused and must act as pass-through.
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned PHASE_PIXELS = 205;
  localparam int unsigned DRAIN_CYCLES = 40;

  // One converted pixel as it leaves the block.
  typedef struct packed {
    logic [rapm_pkg::CHAN_W-1:0] red;
    logic [rapm_pkg::CHAN_W-1:0] green;
    logic [rapm_pkg::CHAN_W-1:0] blue;
    logic [rapm_pkg::CHAN_W-1:0] alpha;
    logic                        overflow;
    logic                        last;
  } conv_pix_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rapm_cfg_if     cfg_bus ();
  rapm_pix_in_if  pix_in_bus ();
  rapm_pix_out_if pix_out_bus ();

  // Pixels waiting to be driven, and converted pixels still owed by the block.
  rapm_pkg::pix_t pixels_to_send[$];
  conv_pix_t      pixels_due[$];

  logic [1:0]  mode_copy = rapm_pkg::MODE_PASS;
  bit          in_taken = 1'b0;
  bit          out_taken = 1'b0;
  bit          no_idle = 1'b0;
  int unsigned send_gap = 0;
  int unsigned recv_stall = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;

  rgba16_alpha_premultiply_convert uut (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_bus),
    .pix_in  (pix_in_bus),
    .pix_out (pix_out_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Converts one pixel the way the block should under the given mode.
  function automatic conv_pix_t convert_pixel(rapm_pkg::pix_t p, logic [1:0] m);
    conv_pix_t   r;
    logic [15:0] colour [3];
    logic [31:0] wide;
    colour[0] = p.red;
    colour[1] = p.green;
    colour[2] = p.blue;
    r.overflow = 1'b0;
    for (int i = 0; i < 3; i++) begin
      unique case (m)
        rapm_pkg::MODE_UNPREMUL: begin
          // Zero alpha clears the colour; a quotient above full scale saturates.
          if (p.alpha == '0) begin
            colour[i] = '0;
          end else begin
            wide = ({16'd0, colour[i]} * 32'd65535) / {16'd0, p.alpha};
            if (wide > 32'd65535) begin
              colour[i] = rapm_pkg::CHAN_MAX;
              r.overflow = 1'b1;
            end else begin
              colour[i] = wide[15:0];
            end
          end
        end
        rapm_pkg::MODE_PREMUL: begin
          wide = {16'd0, colour[i]} * {16'd0, p.alpha};
          colour[i] = wide[31:16];
        end
        default: begin
        end
      endcase
    end
    r.red = colour[0];
    r.green = colour[1];
    r.blue = colour[2];
    r.alpha = p.alpha;
    r.last = p.last;
    return r;
  endfunction

  // Channel value biased toward the edges of the range.
  function automatic logic [15:0] pick_sample();
    unique case ($urandom_range(0, 7))
      0: return '0;
      1: return rapm_pkg::CHAN_MAX;
      2: return 16'($urandom_range(1, 15));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Random pixel; for unpremultiply most colours stay at or below alpha.
  function automatic rapm_pkg::pix_t random_pixel(logic [1:0] m);
    rapm_pkg::pix_t p;
    logic [15:0]    colour [3];
    p.alpha = pick_sample();
    for (int i = 0; i < 3; i++) begin
      if (m == rapm_pkg::MODE_UNPREMUL && $urandom_range(0, 3) != 0) begin
        colour[i] = 16'($urandom_range(0, p.alpha));
      end else begin
        colour[i] = pick_sample();
      end
    end
    p.red = colour[0];
    p.green = colour[1];
    p.blue = colour[2];
    p.last = ($urandom_range(0, 15) == 0);
    return p;
  endfunction

  task automatic queue_pixel(input logic [15:0] r, input logic [15:0] g, input logic [15:0] b,
                             input logic [15:0] a, input logic l);
    pixels_to_send.push_back('{red: r, green: g, blue: b, alpha: a, last: l});
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Waits until nothing is queued, driven or owed by the block.
  task automatic wait_idle();
    do @(posedge clk);
    while (pixels_to_send.size() != 0 || pix_in_bus.valid || pixels_due.size() != 0);
  endtask

  // Writes the mode register once the pipeline is empty.
  task automatic set_mode(input logic [1:0] m);
    wait_idle();
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.data <= m;
    do @(posedge clk);
    while (!cfg_bus.ready);
    mode_copy = m;
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  // Cycle limit.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Each input transfer records the converted pixel it should produce.
  always @(posedge clk) begin : input_watch
    rapm_pkg::pix_t p;
    if (!rst && pix_in_bus.valid && pix_in_bus.ready) begin
      p.red = pix_in_bus.red_in;
      p.green = pix_in_bus.green_in;
      p.blue = pix_in_bus.blue_in;
      p.alpha = pix_in_bus.alpha_in;
      p.last = pix_in_bus.last_in;
      pixels_due.push_back(convert_pixel(p, mode_copy));
      in_taken = 1'b1;
    end
  end

  // Pixel driver: presents queued pixels with a random gap after each transfer.
  always @(negedge clk) begin : pixel_driver
    rapm_pkg::pix_t p;
    if (rst) begin
      pix_in_bus.valid <= 1'b0;
      pix_in_bus.red_in <= '0;
      pix_in_bus.green_in <= '0;
      pix_in_bus.blue_in <= '0;
      pix_in_bus.alpha_in <= '0;
      pix_in_bus.last_in <= 1'b0;
      in_taken = 1'b0;
      send_gap = 0;
    end else if (!pix_in_bus.valid || in_taken) begin
      in_taken = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        pix_in_bus.valid <= 1'b0;
      end else if (pixels_to_send.size() > 0) begin
        p = pixels_to_send.pop_front();
        pix_in_bus.red_in <= p.red;
        pix_in_bus.green_in <= p.green;
        pix_in_bus.blue_in <= p.blue;
        pix_in_bus.alpha_in <= p.alpha;
        pix_in_bus.last_in <= p.last;
        pix_in_bus.valid <= 1'b1;
        send_gap = no_idle ? 0 : $urandom_range(0, 9);
      end else begin
        pix_in_bus.valid <= 1'b0;
      end
    end
  end

  // Output ready: drops for a random number of cycles after each transfer.
  always @(negedge clk) begin
    if (rst) begin
      pix_out_bus.ready <= 1'b0;
      recv_stall = 0;
      out_taken = 1'b0;
    end else begin
      if (out_taken) begin
        out_taken = 1'b0;
        recv_stall = no_idle ? 0 : $urandom_range(0, 9);
      end
      if (recv_stall > 0) begin
        recv_stall--;
        pix_out_bus.ready <= 1'b0;
      end else begin
        pix_out_bus.ready <= 1'b1;
      end
    end
  end

  // Output monitor: compares each transfer with the oldest owed pixel.
  always @(posedge clk) begin : output_monitor
    conv_pix_t got;
    conv_pix_t want;
    if (!rst && pix_out_bus.valid && pix_out_bus.ready) begin
      got.red = pix_out_bus.red_out;
      got.green = pix_out_bus.green_out;
      got.blue = pix_out_bus.blue_out;
      got.alpha = pix_out_bus.alpha_out;
      got.overflow = pix_out_bus.overflow;
      got.last = pix_out_bus.last_out;
      out_taken = 1'b1;
      if (pixels_due.size() == 0) begin
        $display("%0t ns: unexpected pixel, expected none, actual %h", $time, got);
        mismatches++;
      end else begin
        want = pixels_due.pop_front();
        check_field("red", want.red, got.red);
        check_field("green", want.green, got.green);
        check_field("blue", want.blue, got.blue);
        check_field("alpha", want.alpha, got.alpha);
        check_field("overflow", {15'd0, want.overflow}, {15'd0, got.overflow});
        check_field("last", {15'd0, want.last}, {15'd0, got.last});
      end
    end
  end

  // Stimulus sequence and end of run.
  initial begin : stimulus
    logic [1:0] phase_modes [8];
    phase_modes = '{rapm_pkg::MODE_UNPREMUL, rapm_pkg::MODE_PREMUL, rapm_pkg::MODE_PASS,
                    rapm_pkg::MODE_UNPREMUL, MODE_UNUSED, rapm_pkg::MODE_PREMUL,
                    rapm_pkg::MODE_UNPREMUL, rapm_pkg::MODE_PREMUL};
    cfg_bus.valid = 1'b0;
    cfg_bus.data = '0;
    pix_in_bus.valid = 1'b0;
    pix_in_bus.red_in = '0;
    pix_in_bus.green_in = '0;
    pix_in_bus.blue_in = '0;
    pix_in_bus.alpha_in = '0;
    pix_in_bus.last_in = 1'b0;
    pix_out_bus.ready = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Pass-through at the range extremes.
    set_mode(rapm_pkg::MODE_PASS);
    queue_pixel(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    queue_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    queue_pixel(16'h1234, 16'hABCD, 16'h5555, 16'hAAAA, 1'b0);

    // Unpremultiply: zero alpha, exact full scale, saturation on all or one channel.
    set_mode(rapm_pkg::MODE_UNPREMUL);
    queue_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b0);
    queue_pixel(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1);
    queue_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    queue_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0001, 1'b1);
    queue_pixel(16'h8001, 16'h7FFF, 16'h0000, 16'h8000, 1'b0);
    queue_pixel(16'h0001, 16'h0002, 16'h0003, 16'hFFFF, 1'b0);
    queue_pixel(16'h0000, 16'h0000, 16'h0000, 16'h0001, 1'b0);
    queue_pixel(16'h0001, 16'h0001, 16'h0001, 16'h0001, 1'b0);
    queue_pixel(16'h0002, 16'h0001, 16'h0000, 16'h0001, 1'b1);

    // Premultiply: full scale, zero and tiny alpha, half alpha.
    set_mode(rapm_pkg::MODE_PREMUL);
    queue_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    queue_pixel(16'hFFFF, 16'h8000, 16'h0001, 16'h0000, 1'b1);
    queue_pixel(16'hFFFF, 16'h8000, 16'h0001, 16'h0001, 1'b0);
    queue_pixel(16'h1234, 16'h5678, 16'h9ABC, 16'h8000, 1'b0);

    // The unused mode code passes pixels through, with no overflow even above alpha.
    set_mode(MODE_UNUSED);
    queue_pixel(16'hFFFF, 16'h0001, 16'h8000, 16'h0000, 1'b1);
    queue_pixel(16'hCAFE, 16'h0F0F, 16'hF0F0, 16'h0010, 1'b0);

    // Random phases; each pauses halfway until the pipeline has emptied.
    foreach (phase_modes[ph]) begin
      set_mode(phase_modes[ph]);
      no_idle = (ph % 3 == 2);
      for (int n = 0; n < PHASE_PIXELS; n++) begin
        if (n == PHASE_PIXELS / 2) wait_idle();
        pixels_to_send.push_back(random_pixel(phase_modes[ph]));
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/rapm_pkg.sv
src/rapm_if.sv
src/rapm_prep.sv
src/rapm_cell.sv
src/rgba16_alpha_premultiply_convert.sv
sim/rgba16_alpha_premultiply_convert_tb.sv
